### rtl/bplc_pkg.sv
// Package for the bit-plane line compressor.
// Holds the shared constants, controller states and command/status types.
// No dependencies.
`timescale 1ns / 1ps
package bplc_pkg;
	localparam int LINE_WORDS = 32;
	localparam int ROW_W = $clog2(LINE_WORDS);
	localparam int RUN_MAX = LINE_WORDS - 1;

	// Code prefixes and lengths.
	localparam logic [31:0] CODE_ZERO_ROW = 32'd1;
	localparam logic [5:0] LEN_ZERO_ROW = 6'd3;
	localparam logic [31:0] CODE_RUN_PFX = 32'd1;
	localparam logic [5:0] LEN_RUN = 6'd7;
	localparam logic [31:0] CODE_ONES = 32'd0;
	localparam logic [5:0] LEN_SHORT = 6'd5;
	localparam logic [31:0] CODE_PAIR_PFX = 32'd2;
	localparam logic [31:0] CODE_SINGLE_PFX = 32'd3;
	localparam logic [5:0] LEN_POS = 6'd10;
	localparam logic [31:0] CODE_PLANE_ZERO = 32'd1;
	localparam logic [5:0] LEN_RAW = 6'd32;

	// Rotation codes.
	localparam logic [1:0] ROT_90 = 2'd0;
	localparam logic [1:0] ROT_180 = 2'd1;
	localparam logic [1:0] ROT_270 = 2'd2;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_TRIAL,
		ST_BUILD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic trial;
		logic build;
		logic emit;
		logic row_first;
		logic row_last;
		logic [1:0] rot;
		logic [ROW_W-1:0] row;
	} cmd_t;

	typedef struct packed {
		logic emit_done;
	} status_t;
endpackage

### rtl/bit_plane_line_compressor_top.sv
// Bit-plane line compressor: one line of 32 words in, a burst of codes out.
// Channel data: data_word beats with data_valid/data_stall. Channel code:
// code_value, code_length, rotation_used and last_code with code_valid/code_stall.
// A line is 32 beats, one per cycle; data_stall is high while a line is
// being processed. After the 32nd beat the three rotation trials run one row
// per cycle on the shared row scorer, the chosen plane is then built, and then
// one plane row is examined per cycle while the code channel does not stall, so
// up to 32 codes follow, the last marked by last_code. Each phase walks the
// rows of the 32x32 bit matrix.
// A stall on the code channel holds the output register and pauses the row
// walk; data is not taken again until the final code of the line is in the
// output register. Reset clears control state and empties the output; the
// line and plane stores hold no reset value and are fully rewritten per line.
// Depends on bplc_pkg, bplc_ctrl and bplc_datapath.
`timescale 1ns / 1ps
module bit_plane_line_compressor_top (
	input logic clk,
	input logic arst_n,
	input logic data_valid,
	output logic data_stall,
	input logic [31:0] data_word,
	output logic code_valid,
	input logic code_stall,
	output logic [31:0] code_value,
	output logic [5:0] code_length,
	output logic [1:0] rotation_used,
	output logic last_code
);
	import bplc_pkg::*;

	cmd_t cmd;
	status_t st;

	bplc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.st(st),
		.cmd(cmd)
	);

	bplc_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.data_word(data_word),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_value(code_value),
		.code_length(code_length),
		.rotation_used(rotation_used),
		.last_code(last_code)
	);

	// A delivered code always has a legal length.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> (code_length >= 6'd3 && code_length <= 6'd32))
		else $error("code length out of range");

	// The rotation reported is one of the three trials.
	a_rot: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> (rotation_used != 2'd3))
		else $error("illegal rotation");

	// After the final code of a line is taken, no code follows at once.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(code_valid && last_code && !code_stall) |=> !code_valid)
		else $error("code after end of line");

	// Input is never taken while codes of the line are still being formed.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.trial || cmd.build) |-> data_stall)
		else $error("input taken while busy");
endmodule

### rtl/bplc_ctrl.sv
// Controller of the bit-plane line compressor: phase sequencing and row counters.
// Depends on bplc_pkg.
`timescale 1ns / 1ps
module bplc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic data_valid,
	output logic data_stall,
	input bplc_pkg::status_t st,
	output bplc_pkg::cmd_t cmd
);
	import bplc_pkg::*;

	state_t state_q, state_d;
	logic [ROW_W-1:0] row_q;
	logic [1:0] rot_q;
	logic row_last;
	logic accept;

	assign row_last = (row_q == ROW_W'(LINE_WORDS - 1));
	assign accept = data_valid && !data_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (accept && row_last) state_d = ST_TRIAL;
			ST_TRIAL: if (row_last && rot_q == ROT_270) state_d = ST_BUILD;
			ST_BUILD: if (row_last) state_d = ST_EMIT;
			ST_EMIT: if (st.emit_done) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		data_stall = 1'b1;
		cmd.rot = rot_q;
		cmd.row = row_q;
		cmd.row_first = (row_q == '0);
		cmd.row_last = row_last;
		case (state_q)
			ST_LOAD: begin
				data_stall = 1'b0;
				cmd.load = data_valid;
			end
			ST_TRIAL: cmd.trial = 1'b1;
			ST_BUILD: cmd.build = 1'b1;
			ST_EMIT: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			row_q <= '0;
			rot_q <= ROT_90;
		end else begin
			state_q <= state_d;
			if (accept || state_q == ST_TRIAL || state_q == ST_BUILD) begin
				row_q <= row_q + 1'b1;
			end
			if (state_q == ST_TRIAL && row_last) begin
				rot_q <= (rot_q == ROT_270) ? ROT_90 : rot_q + 1'b1;
			end
		end
	end
endmodule

### rtl/bplc_datapath.sv
// Datapath of the bit-plane line compressor: line store, rotation scoring,
// plane shift line, code formation and the output register. Depends on bplc_pkg.
`timescale 1ns / 1ps
module bplc_datapath (
	input logic clk,
	input logic arst_n,
	input bplc_pkg::cmd_t cmd,
	output bplc_pkg::status_t st,
	input logic [31:0] data_word,
	output logic code_valid,
	input logic code_stall,
	output logic [31:0] code_value,
	output logic [5:0] code_length,
	output logic [1:0] rotation_used,
	output logic last_code
);
	import bplc_pkg::*;

	logic [31:0] line_q [LINE_WORDS];
	logic [31:0] plane_q [LINE_WORDS];
	logic [31:0] prev_q;
	logic [5:0] count_q;
	logic [5:0] best_q;
	logic [1:0] chosen_q;
	logic seen_q;
	logic [5:0] rows_left_q;
	logic [4:0] run_q;

	logic [ROW_W-1:0] row_rev;
	logic [1:0] rot_sel;
	logic [31:0] r0, r1, r2, w;
	logic w_zero, w_seen;
	logic [5:0] cnt_fin;
	logic seen_fin;

	assign row_rev = ~cmd.row;
	assign rot_sel = cmd.build ? chosen_q : cmd.rot;

	// Rotated row of the line matrix.
	always_comb begin
		for (int j = 0; j < 32; j++) begin
			r0[j] = line_q[j][row_rev];
			r1[j] = line_q[row_rev][31-j];
			r2[j] = line_q[31-j][cmd.row];
		end
		case (rot_sel)
			ROT_90: w = r0;
			ROT_180: w = r1;
			ROT_270: w = r2;
			default: w = r0;
		endcase
	end

	// Scoring of one row of a trial.
	assign w_zero = (w == '0);
	assign w_seen = |((~w >> 1) & w);
	assign cnt_fin = (cmd.row_first ? 6'd0 : count_q) + {5'd0, w_zero};
	assign seen_fin = (cmd.row_first ? 1'b0 : seen_q) | w_seen;

	// Emission: head rows of the plane and the code for the head.
	logic [31:0] x, nx, low;
	logic [4:0] low_idx;
	logic step, last_row, run_emit, emit_code;
	logic [4:0] run_n;
	logic [31:0] val_d;
	logic [5:0] len_d;

	assign x = plane_q[0] ^ plane_q[1];
	assign nx = plane_q[1] ^ plane_q[2];
	assign low = x & (~x + 32'd1);
	assign step = cmd.emit && (!code_valid || !code_stall);
	assign last_row = (rows_left_q == 6'd1);
	assign run_n = run_q + 5'd1;
	assign run_emit = (run_n == 5'(RUN_MAX)) || last_row || (nx != '0);
	assign emit_code = (x != '0) || run_emit;
	assign st.emit_done = step && last_row;

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < 32; i++) begin
			if (low[i]) low_idx = low_idx | 5'(i);
		end
	end

	always_comb begin
		val_d = '0;
		len_d = LEN_RAW;
		if (x == '0) begin
			if (run_n == 5'd1) begin
				val_d = CODE_ZERO_ROW;
				len_d = LEN_ZERO_ROW;
			end else begin
				val_d = (CODE_RUN_PFX << 5) | {27'd0, run_n};
				len_d = LEN_RUN;
			end
		end else if (x == '1) begin
			val_d = CODE_ONES;
			len_d = LEN_SHORT;
		end else if (!low[31] && x == (low | (low << 1))) begin
			// Two adjacent ones and nothing else.
			val_d = (CODE_PAIR_PFX << 5) | {27'd0, 5'd30 - low_idx};
			len_d = LEN_POS;
		end else if (x == low) begin
			val_d = (CODE_SINGLE_PFX << 5) | {27'd0, 5'd31 - low_idx};
			len_d = LEN_POS;
		end else if (plane_q[0] == '0) begin
			val_d = CODE_PLANE_ZERO;
			len_d = LEN_SHORT;
		end else begin
			val_d = x;
			len_d = LEN_RAW;
		end
	end

	// Line and plane shift lines.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			line_q[LINE_WORDS-1] <= cmd.row_first ? data_word : data_word - prev_q;
			for (int i = 0; i < LINE_WORDS - 1; i++) line_q[i] <= line_q[i+1];
		end
		if (cmd.build) begin
			plane_q[LINE_WORDS-1] <= w;
			for (int i = 0; i < LINE_WORDS - 1; i++) plane_q[i] <= plane_q[i+1];
		end else if (step) begin
			plane_q[LINE_WORDS-1] <= '0;
			for (int i = 0; i < LINE_WORDS - 1; i++) plane_q[i] <= plane_q[i+1];
		end
		if (step && emit_code) begin
			code_value <= val_d;
			code_length <= len_d;
			rotation_used <= chosen_q;
			last_code <= last_row;
		end
	end

	// Control registers: scoring, run counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			count_q <= '0;
			best_q <= '0;
			chosen_q <= ROT_90;
			seen_q <= 1'b0;
			rows_left_q <= '0;
			run_q <= '0;
			code_valid <= 1'b0;
		end else begin
			if (cmd.load) prev_q <= data_word;
			if (cmd.trial) begin
				count_q <= cnt_fin;
				seen_q <= seen_fin;
				if (cmd.row_last) begin
					if (cnt_fin > (cmd.rot == ROT_90 ? 6'd0 : best_q)) begin
						best_q <= cnt_fin;
						chosen_q <= cmd.rot;
					end else if (seen_fin) begin
						chosen_q <= cmd.rot;
						if (cmd.rot == ROT_90) best_q <= '0;
					end else if (cmd.rot == ROT_90) begin
						best_q <= '0;
						chosen_q <= ROT_90;
					end
				end
			end
			if (cmd.build) rows_left_q <= 6'(LINE_WORDS);
			if (step) begin
				rows_left_q <= rows_left_q - 6'd1;
				if (x == '0 && !run_emit) run_q <= run_n;
				else run_q <= '0;
			end
			if (step && emit_code) code_valid <= 1'b1;
			else if (!code_stall) code_valid <= 1'b0;
		end
	end
endmodule

### bench/bplc_checker.sv
// Checker for the bit-plane line compressor: watches both channels, predicts
// the code stream of each finished line and compares it beat by beat.
// Depends on bplc_pkg for the code lengths and rotation codes.
`timescale 1ns / 1ps
module bplc_checker (
	input logic clk,
	input logic arst_n,
	input logic data_valid,
	input logic data_stall,
	input logic [31:0] data_word,
	input logic code_valid,
	input logic code_stall,
	input logic [31:0] code_value,
	input logic [5:0] code_length,
	input logic [1:0] rotation_used,
	input logic last_code,
	output int fail_count,
	output int pending_codes,
	output int codes_seen,
	output int lines_seen
);
	import bplc_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic [5:0] length;
		logic [1:0] rot;
		logic last;
	} code_t;

	code_t expected_codes[$];
	logic [31:0] line_mem[LINE_WORDS];
	logic [31:0] prev_word;
	int word_idx;

	// Row r of the line matrix rotated by (rot + 1) * 90 degrees.
	function automatic logic [31:0] rotate_row(logic [1:0] rot, int r);
		logic [31:0] res;
		res = '0;
		for (int c = 0; c < 32; c++) begin
			if (rot == ROT_90)
				res[31-c] = line_mem[31-c][31-r];
			else if (rot == ROT_180)
				res[31-c] = line_mem[31-r][c];
			else
				res[31-c] = line_mem[c][r];
		end
		return res;
	endfunction

	function automatic void push_code(logic [31:0] v, logic [5:0] l, logic [1:0] rot);
		code_t e;
		e.value = v;
		e.length = l;
		e.rot = rot;
		e.last = 1'b0;
		expected_codes = {expected_codes, e};
	endfunction

	// Pick a rotation, build the XOR plane and queue the codes of the line.
	function automatic void compress_line();
		logic [31:0] rows[LINE_WORDS];
		logic [31:0] xr[LINE_WORDS];
		logic [1:0] best_rot;
		int best_zero, cnt, i, run, c;
		logic seen, done;
		logic [31:0] w, x;
		best_zero = 0;
		best_rot = ROT_90;
		for (int rot = 0; rot < 3; rot++) begin
			cnt = 0;
			seen = 1'b0;
			for (int r = 0; r < 32; r++) begin
				w = rotate_row(rot[1:0], r);
				if (w == 0) cnt++;
				else if (((~w) >> 1) & w) seen = 1'b1;
			end
			if (cnt > best_zero) begin
				best_zero = cnt;
				best_rot = rot[1:0];
			end else if (seen) begin
				best_rot = rot[1:0];
			end
		end
		for (int r = 0; r < 32; r++) rows[r] = rotate_row(best_rot, r);
		for (int r = 0; r < 32; r++) xr[r] = (r < 31) ? rows[r] ^ rows[r+1] : rows[r];
		i = 0;
		while (i < 32) begin
			x = xr[i];
			if (x == 0) begin
				run = 0;
				while (i + run < 32 && xr[i+run] == 0 && run < RUN_MAX) run++;
				if (run == 1) push_code(CODE_ZERO_ROW, LEN_ZERO_ROW, best_rot);
				else push_code((CODE_RUN_PFX << 5) | run, LEN_RUN, best_rot);
				i += run;
			end else begin
				done = 1'b0;
				if (x == 32'hFFFF_FFFF) begin
					push_code(CODE_ONES, LEN_SHORT, best_rot);
					done = 1'b1;
				end
				if (!done) begin
					for (c = 0; c < 31; c++)
						if (((x >> (30 - c)) & 3) == 3) break;
					if (c < 31 && x == (32'd3 << (30 - c))) begin
						push_code((CODE_PAIR_PFX << 5) | c, LEN_POS, best_rot);
						done = 1'b1;
					end
				end
				if (!done) begin
					for (c = 0; c < 32; c++)
						if (x[31-c]) break;
					if (c < 32 && x == (32'd1 << (31 - c))) begin
						push_code((CODE_SINGLE_PFX << 5) | c, LEN_POS, best_rot);
						done = 1'b1;
					end
				end
				if (!done) begin
					if (rows[i] == 0) push_code(CODE_PLANE_ZERO, LEN_SHORT, best_rot);
					else push_code(x, LEN_RAW, best_rot);
				end
				i++;
			end
		end
		expected_codes[$].last = 1'b1;
	endfunction

	assign pending_codes = expected_codes.size();

	// Accept data beats into the line image and compare code beats.
	always @(posedge clk or negedge arst_n) begin
		code_t e;
		if (!arst_n) begin
			word_idx = 0;
			prev_word = '0;
			fail_count = 0;
			codes_seen = 0;
			lines_seen = 0;
		end else begin
			if (code_valid && !code_stall) begin
				codes_seen++;
				if (expected_codes.size() == 0) begin
					$display("%0t: unexpected code beat value=%h len=%0d", $time,
						code_value, code_length);
					fail_count++;
				end else begin
					e = expected_codes.pop_front();
					if (e.value !== code_value || e.length !== code_length ||
						e.rot !== rotation_used || e.last !== last_code) begin
						$display("%0t: code mismatch expected %h/%0d/%0d/%0b actual %h/%0d/%0d/%0b",
							$time, e.value, e.length, e.rot, e.last,
							code_value, code_length, rotation_used, last_code);
						fail_count++;
					end
				end
			end
			if (data_valid && !data_stall) begin
				line_mem[word_idx] = (word_idx == 0) ? data_word : data_word - prev_word;
				prev_word = data_word;
				word_idx++;
				if (word_idx == LINE_WORDS) begin
					word_idx = 0;
					lines_seen++;
					compress_line();
				end
			end
		end
	end
endmodule

### bench/tb.sv
// Top of the compressor testbench: clock, reset, line stimulus with idling
// phases and the final verdict. Depends on bplc_checker and the block.
`timescale 1ns / 1ps
module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic data_valid = 1'b0;
	logic [31:0] data_word = '0;
	logic code_stall = 1'b0;
	logic data_stall, code_valid, last_code;
	logic [31:0] code_value;
	logic [5:0] code_length;
	logic [1:0] rotation_used;
	int fail_count, pending_codes, codes_seen, lines_seen;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	longint cycle_count = 0;
	logic [31:0] line_buf[32];

	always #5 clk = ~clk;

	bit_plane_line_compressor_top i_dut (.*);

	bplc_checker i_checker (.*);

	// The receiver stalls at random, or fully during a hold-off.
	always @(posedge clk) begin
		code_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 1_500_000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offer one word and wait until the block takes it. Valid stays high
	// after the beat so that the next word can follow without a gap.
	task automatic send_word(logic [31:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid <= 1'b1;
		data_word <= w;
		@(posedge clk);
		while (data_stall) @(posedge clk);
	endtask

	// Sending the undifferenced values gives lines of chosen difference content.
	task automatic send_line_diff();
		logic [31:0] acc;
		acc = line_buf[0];
		send_word(acc);
		for (int k = 1; k < 32; k++) begin
			acc = acc + line_buf[k];
			send_word(acc);
		end
	endtask

	// Fill line_buf with a line of the given flavor.
	task automatic make_line(int kind);
		int p;
		for (int k = 0; k < 32; k++) begin
			case (kind)
				0: line_buf[k] = '0;
				1: line_buf[k] = 32'hFFFF_FFFF;
				2: line_buf[k] = $urandom();
				3: line_buf[k] = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
				4: begin
					p = $urandom_range(31);
					line_buf[k] = ($urandom_range(1)) ? (32'd1 << p) : 32'd0;
				end
				5: line_buf[k] = (k % 2) ? 32'hAAAA_AAAA : 32'h5555_5555;
				6: line_buf[k] = ($urandom_range(1)) ? (32'd3 << $urandom_range(30)) :
					(32'd1 << $urandom_range(31));
				default: line_buf[k] = $urandom() & $urandom() & $urandom();
			endcase
		end
	endtask

	task automatic wait_drained();
		while (pending_codes != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed lines: all zero, all ones, random, sparse, one bit, stripes and pairs.
		for (int kind = 0; kind < 7; kind++) begin
			make_line(kind);
			send_line_diff();
		end
		data_valid <= 1'b0;
		wait_drained();
		// Random lines under each idling phase.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 32 : 0;
			recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 32 : 0;
			for (int n = 0; n < 1; n++) begin
				make_line($urandom_range(7));
				send_line_diff();
			end
			if (ph == 0) begin
				// Long hold-off on the code channel while lines keep coming.
				fork
					begin
						hold_off = 1'b1;
						for (int c = 0; c < 600; c++) @(posedge clk);
						hold_off = 1'b0;
					end
					begin
						make_line(2);
						send_line_diff();
						make_line(3);
						send_line_diff();
					end
				join
			end
		end
		data_valid <= 1'b0;
		wait_drained();
		$display("Covered %0d lines and %0d code beats over four idling phases.",
			lines_seen, codes_seen);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
